@@ hdl/alt_pkg.sv @@
// ----------------------------------------------------------------------------
// alt_pkg: shared definitions of the array list table
// Command and status codes, field widths and the words that travel along
// the chain of list cells.
// ----------------------------------------------------------------------------
package alt_pkg;

   // Default list capacity.
   localparam int LIST_DEPTH_DEF = 16;

   // Field widths.
   localparam int CMD_W   = 3;
   localparam int POS_W   = 8;
   localparam int KEY_W   = 64;
   localparam int NAME_W  = 64;
   localparam int AGE_W   = 16;
   localparam int STAT_W  = 3;
   localparam int COUNT_W = 5;
   // Wide enough to hold any list length up to 256.
   localparam int LEN_WIDE_W = 9;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd5;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

   // One stored record.
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [NAME_W-1:0] name;
      logic [AGE_W-1:0]  age;
   } entry_type;

   // Update control broadcast to every cell.
   typedef struct packed {
      logic             append;
      logic             insert;
      logic             delete;
      logic [POS_W-1:0] pos;
      entry_type        entry;
   } ctrl_type;

   // Query broadcast to every cell while a scan runs.
   typedef struct packed {
      logic             find;
      logic [POS_W-1:0] pos;
      logic [KEY_W-1:0] key;
   } query_type;

   // Scan word handed from cell to cell.
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [POS_W-1:0] pos;
      entry_type        entry;
   } scan_type;

endpackage

@@ hdl/alt_cell.sv @@
// ----------------------------------------------------------------------------
// alt_cell: one slot of the list
// Holds one record, shifts it to or from its neighbors on insert and
// delete, and registers the scan word before passing it on to the next cell.
// ----------------------------------------------------------------------------
module alt_cell #(
   parameter int LIST_DEPTH = alt_pkg::LIST_DEPTH_DEF,
   parameter int IDX        = 0,
   parameter int LEN_W      = $clog2(LIST_DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  alt_pkg::ctrl_type   ctrl,
   input  alt_pkg::query_type  query,
   input  logic [LEN_W-1:0]    len,
   input  alt_pkg::entry_type  left_entry,
   input  alt_pkg::entry_type  right_entry,
   output alt_pkg::entry_type  entry,
   input  alt_pkg::scan_type   scan_prev,
   output alt_pkg::scan_type   scan_next
);

   localparam logic [alt_pkg::POS_W-1:0] MY_IDX = alt_pkg::POS_W'(IDX);

   alt_pkg::entry_type entry_ff, entry_in;
   alt_pkg::scan_type  scan_ff, scan_in;
   logic [alt_pkg::LEN_WIDE_W-1:0] len_wide;
   logic occupied;
   logic match;

   assign len_wide = alt_pkg::LEN_WIDE_W'(len);
   assign occupied = ({1'b0, MY_IDX} < len_wide);

   // Record update: load a new record, or take the neighbor's record.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.append && (len_wide == {1'b0, MY_IDX})) begin
         entry_in = ctrl.entry;
      end else if (ctrl.insert && (MY_IDX == ctrl.pos)) begin
         entry_in = ctrl.entry;
      end else if (ctrl.insert && (MY_IDX > ctrl.pos)) begin
         entry_in = left_entry;
      end else if (ctrl.delete && (MY_IDX >= ctrl.pos)) begin
         entry_in = right_entry;
      end
   end

   // Scan step: the first cell that matches claims the word.
   assign match = occupied && (query.find ? (entry_ff.key == query.key)
                                          : (MY_IDX == query.pos));

   always_comb begin
      scan_in       = scan_prev;
      if (scan_prev.valid && !scan_prev.hit && match) begin
         scan_in.hit   = 1'b1;
         scan_in.pos   = MY_IDX;
         scan_in.entry = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.valid <= 1'b0;
      end else begin
         scan_ff.valid <= scan_in.valid;
      end
      scan_ff.hit   <= scan_in.hit;
      scan_ff.pos   <= scan_in.pos;
      scan_ff.entry <= scan_in.entry;
   end

   assign entry     = entry_ff;
   assign scan_next = scan_ff;

endmodule

@@ hdl/array_list_insert_delete_table.sv @@
// ----------------------------------------------------------------------------
// array_list_insert_delete_table: fixed-capacity ordered list of records
//
//   channel   direction  handshake        word
//   req_      in         valid / ready    command, position, key, name, age
//   rsp_      out        valid / ready    status, position, key, name, age,
//                                         entry count
//
// Clear, append, insert, delete and every command that fails its checks
// give their result in the cycle after acceptance; all cells shift at once.
// Read and find send a scan word through the chain of cells, one cell a
// cycle, and their result is registered once the word leaves the last cell.
// One command is worked at a time; a new word is taken once the result
// register is free or being emptied. Reset empties the list.
// ----------------------------------------------------------------------------
module array_list_insert_delete_table #(
   parameter int LIST_DEPTH = alt_pkg::LIST_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [alt_pkg::CMD_W-1:0]     req_command,
   input  logic [alt_pkg::POS_W-1:0]     req_position,
   input  logic [alt_pkg::KEY_W-1:0]     req_key_in,
   input  logic [alt_pkg::NAME_W-1:0]    req_name_in,
   input  logic [alt_pkg::AGE_W-1:0]     req_age_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [alt_pkg::STAT_W-1:0]    rsp_status,
   output logic [alt_pkg::POS_W-1:0]     rsp_found_position,
   output logic [alt_pkg::KEY_W-1:0]     rsp_key_out,
   output logic [alt_pkg::NAME_W-1:0]    rsp_name_out,
   output logic [alt_pkg::AGE_W-1:0]     rsp_age_out,
   output logic [alt_pkg::COUNT_W-1:0]   rsp_entry_count
);

   localparam int LEN_W = $clog2(LIST_DEPTH + 1);
   localparam int LW    = alt_pkg::LEN_WIDE_W;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic start_ff, start_in;
   alt_pkg::query_type query_ff, query_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [alt_pkg::STAT_W-1:0]  status_ff, status_in;
   logic [alt_pkg::POS_W-1:0]   fpos_ff, fpos_in;
   logic [alt_pkg::KEY_W-1:0]   kout_ff, kout_in;
   logic [alt_pkg::NAME_W-1:0]  nout_ff, nout_in;
   logic [alt_pkg::AGE_W-1:0]   aout_ff, aout_in;

   logic accept;
   logic full, empty, pos_ok;
   logic [LW-1:0] len_wide, len_next_wide;
   alt_pkg::ctrl_type ctrl;
   alt_pkg::entry_type new_entry;

   alt_pkg::entry_type cell_entry [LIST_DEPTH];
   alt_pkg::scan_type  scan_link  [LIST_DEPTH+1];

   // Handshake and list checks.
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign len_wide  = LW'(len_ff);
   assign full      = (len_wide == LW'(LIST_DEPTH));
   assign empty     = (len_ff == '0);
   assign pos_ok    = ({1'b0, req_position} < len_wide);

   assign new_entry.key  = req_key_in;
   assign new_entry.name = req_name_in;
   assign new_entry.age  = req_age_in;

   // Update control for the cells, applied at the accepting edge.
   always_comb begin
      ctrl.append = accept && (req_command == alt_pkg::CMD_APPEND) && !full;
      ctrl.insert = accept && (req_command == alt_pkg::CMD_INSERT) && !full && pos_ok;
      ctrl.delete = accept && (req_command == alt_pkg::CMD_DELETE) && !empty && pos_ok;
      ctrl.pos    = req_position;
      ctrl.entry  = new_entry;
   end

   // Command sequencing, length and result register.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      start_in     = 1'b0;
      query_in     = query_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      fpos_in      = fpos_ff;
      kout_in      = kout_ff;
      nout_in      = nout_ff;
      aout_in      = aout_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               status_in    = alt_pkg::ST_OK;
               fpos_in      = '0;
               kout_in      = '0;
               nout_in      = '0;
               aout_in      = '0;
               case (req_command)
                  alt_pkg::CMD_CLEAR: begin
                     len_in = '0;
                  end
                  alt_pkg::CMD_APPEND: begin
                     if (full) begin
                        status_in = alt_pkg::ST_FULL;
                     end else begin
                        len_in = len_ff + LEN_W'(1);
                     end
                  end
                  alt_pkg::CMD_INSERT: begin
                     if (full) begin
                        status_in = alt_pkg::ST_FULL;
                     end else if (!pos_ok) begin
                        status_in = alt_pkg::ST_BAD_INDEX;
                     end else begin
                        len_in = len_ff + LEN_W'(1);
                     end
                  end
                  alt_pkg::CMD_DELETE: begin
                     if (empty) begin
                        status_in = alt_pkg::ST_EMPTY;
                     end else if (!pos_ok) begin
                        status_in = alt_pkg::ST_BAD_INDEX;
                     end else begin
                        len_in = len_ff - LEN_W'(1);
                     end
                  end
                  alt_pkg::CMD_READ, alt_pkg::CMD_FIND: begin
                     if (empty) begin
                        status_in = alt_pkg::ST_EMPTY;
                     end else if ((req_command == alt_pkg::CMD_READ) && !pos_ok) begin
                        status_in = alt_pkg::ST_BAD_INDEX;
                     end else begin
                        // Launch a scan; the result waits for the chain.
                        rsp_valid_in   = 1'b0;
                        start_in       = 1'b1;
                        state_in       = S_SCAN;
                        query_in.find  = (req_command == alt_pkg::CMD_FIND);
                        query_in.pos   = req_position;
                        query_in.key   = req_key_in;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_link[LIST_DEPTH].valid) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               fpos_in      = '0;
               kout_in      = '0;
               nout_in      = '0;
               aout_in      = '0;
               if (scan_link[LIST_DEPTH].hit) begin
                  status_in = alt_pkg::ST_OK;
                  nout_in   = scan_link[LIST_DEPTH].entry.name;
                  aout_in   = scan_link[LIST_DEPTH].entry.age;
                  if (query_ff.find) begin
                     fpos_in = scan_link[LIST_DEPTH].pos;
                  end else begin
                     kout_in = scan_link[LIST_DEPTH].entry.key;
                  end
               end else begin
                  status_in = alt_pkg::ST_NOT_FOUND;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      query_ff  <= query_in;
      status_ff <= status_in;
      fpos_ff   <= fpos_in;
      kout_ff   <= kout_in;
      nout_ff   <= nout_in;
      aout_ff   <= aout_in;
   end

   // Scan word entering the first cell.
   always_comb begin
      scan_link[0]       = '0;
      scan_link[0].valid = start_ff;
   end

   // The chain of list cells.
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      alt_pkg::entry_type left_e, right_e;
      if (i == 0) begin : g_first
         assign left_e = '0;
      end else begin : g_mid
         assign left_e = cell_entry[i-1];
      end
      if (i == LIST_DEPTH - 1) begin : g_last
         assign right_e = cell_entry[i];
      end else begin : g_inner
         assign right_e = cell_entry[i+1];
      end
      alt_cell #(
         .LIST_DEPTH (LIST_DEPTH),
         .IDX        (i),
         .LEN_W      (LEN_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .query       (query_ff),
         .len         (len_ff),
         .left_entry  (left_e),
         .right_entry (right_e),
         .entry       (cell_entry[i]),
         .scan_prev   (scan_link[i]),
         .scan_next   (scan_link[i+1])
      );
   end

   // Result ports; the count carries the low bits of the length.
   assign len_next_wide      = LW'(len_ff);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_key_out        = kout_ff;
   assign rsp_name_out       = nout_ff;
   assign rsp_age_out        = aout_ff;
   assign rsp_entry_count    = len_next_wide[alt_pkg::COUNT_W-1:0];

endmodule

@@ hdl/alt_checker.sv @@
// ----------------------------------------------------------------------------
// alt_checker: port-level checks of the array list table
// Watches both channels and flags result words that break the list's rules.
// ----------------------------------------------------------------------------
module alt_checker #(
   parameter int LIST_DEPTH = alt_pkg::LIST_DEPTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [alt_pkg::CMD_W-1:0]     req_command,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [alt_pkg::STAT_W-1:0]    rsp_status,
   input logic [alt_pkg::POS_W-1:0]     rsp_found_position,
   input logic [alt_pkg::KEY_W-1:0]     rsp_key_out,
   input logic [alt_pkg::NAME_W-1:0]    rsp_name_out,
   input logic [alt_pkg::AGE_W-1:0]     rsp_age_out,
   input logic [alt_pkg::COUNT_W-1:0]   rsp_entry_count
);

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count) && $stable(rsp_name_out))
      else $error("stalled result word changed");

   // No new word is taken while a result is stuck.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result register is blocked");

   // A failed command returns no data.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != alt_pkg::ST_OK) |->
         (rsp_key_out == '0) && (rsp_name_out == '0) && (rsp_age_out == '0)
         && (rsp_found_position == '0))
      else $error("failed command returned data");

   // Clear answers in the next cycle with an empty list.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == alt_pkg::CMD_CLEAR) |=>
         rsp_valid && (rsp_entry_count == '0) && (rsp_status == alt_pkg::ST_OK))
      else $error("clear did not empty the list");

   // The count never exceeds the capacity when the capacity fits.
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (LIST_DEPTH >= 32) || (int'(rsp_entry_count) <= LIST_DEPTH))
      else $error("entry count beyond capacity");

endmodule

bind array_list_insert_delete_table alt_checker #(
   .LIST_DEPTH (LIST_DEPTH)
) u_alt_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_command        (req_command),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_found_position (rsp_found_position),
   .rsp_key_out        (rsp_key_out),
   .rsp_name_out       (rsp_name_out),
   .rsp_age_out        (rsp_age_out),
   .rsp_entry_count    (rsp_entry_count)
);

@@ tb/sv/array_list_insert_delete_table_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_list_insert_delete_table_test: self-checking bench of the list table
// Commands go in one word at a time and are scored against a behavioral copy
// of the list kept here. Directed words cover the empty, full and index-error
// cases, the edits at head and tail and one long receiver hold-off. Random
// traffic then runs in phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module array_list_insert_delete_table_test;

   localparam int LIST_DEPTH = alt_pkg::LIST_DEPTH_DEF;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT = 10;
   // Command codes that the block treats as no-ops.
   localparam logic [alt_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
   localparam logic [alt_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
   localparam logic [alt_pkg::KEY_W-1:0] KEY_ONES = '1;
   localparam logic [alt_pkg::KEY_W-1:0] KEY_JOHN = 64'h4A4F_484E_0000_0000;
   localparam logic [alt_pkg::NAME_W-1:0] NAME_ALICE = 64'h414C_4943_4500_0000;

   // One result word as it appears on the rsp_ channel.
   typedef struct packed {
      logic [alt_pkg::STAT_W-1:0]  status;
      logic [alt_pkg::POS_W-1:0]   found_position;
      logic [alt_pkg::KEY_W-1:0]   key;
      logic [alt_pkg::NAME_W-1:0]  name;
      logic [alt_pkg::AGE_W-1:0]   age;
      logic [alt_pkg::COUNT_W-1:0] entry_count;
   } list_result_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [alt_pkg::CMD_W-1:0]     req_command;
   logic [alt_pkg::POS_W-1:0]     req_position;
   logic [alt_pkg::KEY_W-1:0]     req_key_in;
   logic [alt_pkg::NAME_W-1:0]    req_name_in;
   logic [alt_pkg::AGE_W-1:0]     req_age_in;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [alt_pkg::STAT_W-1:0]    rsp_status;
   logic [alt_pkg::POS_W-1:0]     rsp_found_position;
   logic [alt_pkg::KEY_W-1:0]     rsp_key_out;
   logic [alt_pkg::NAME_W-1:0]    rsp_name_out;
   logic [alt_pkg::AGE_W-1:0]     rsp_age_out;
   logic [alt_pkg::COUNT_W-1:0]   rsp_entry_count;

   // Shadow copy of the list contents.
   logic [alt_pkg::KEY_W-1:0]     shadow_keys [LIST_DEPTH];
   logic [alt_pkg::NAME_W-1:0]    shadow_names [LIST_DEPTH];
   logic [alt_pkg::AGE_W-1:0]     shadow_ages [LIST_DEPTH];
   int                            shadow_length;

   list_result_type     pending_results [$];
   list_result_type     oldest_result;
   list_result_type     observed_result;
   int                  mismatch_count;
   int                  sender_idle_pct;
   int                  receiver_stall_pct;
   int                  hold_request;
   int                  hold_left;
   int                  quiet_cycles;

   array_list_insert_delete_table dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_position       (req_position),
      .req_key_in         (req_key_in),
      .req_name_in        (req_name_in),
      .req_age_in         (req_age_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_found_position (rsp_found_position),
      .rsp_key_out        (rsp_key_out),
      .rsp_name_out       (rsp_name_out),
      .rsp_age_out        (rsp_age_out),
      .rsp_entry_count    (rsp_entry_count)
   );

   // 2 ns clock.
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Apply one command to the shadow list and return the word it should produce.
   function automatic list_result_type apply_list_command(
      input logic [alt_pkg::CMD_W-1:0]  cmd,
      input logic [alt_pkg::POS_W-1:0]  pos,
      input logic [alt_pkg::KEY_W-1:0]  key,
      input logic [alt_pkg::NAME_W-1:0] name,
      input logic [alt_pkg::AGE_W-1:0]  age
   );
      list_result_type res;
      bit              hit;
      int              i;
      res = '0;
      hit = 1'b0;
      res.status = alt_pkg::ST_OK;
      case (cmd)
         alt_pkg::CMD_CLEAR: begin
            shadow_length = 0;
         end
         alt_pkg::CMD_APPEND: begin
            if (shadow_length >= LIST_DEPTH) begin
               res.status = alt_pkg::ST_FULL;
            end else begin
               shadow_keys[shadow_length] = key;
               shadow_names[shadow_length] = name;
               shadow_ages[shadow_length] = age;
               shadow_length++;
            end
         end
         alt_pkg::CMD_INSERT: begin
            if (shadow_length >= LIST_DEPTH) begin
               res.status = alt_pkg::ST_FULL;
            end else if (pos >= shadow_length) begin
               // Insert at the tail is rejected as well.
               res.status = alt_pkg::ST_BAD_INDEX;
            end else begin
               for (i = shadow_length; i > pos; i--) begin
                  shadow_keys[i] = shadow_keys[i-1];
                  shadow_names[i] = shadow_names[i-1];
                  shadow_ages[i] = shadow_ages[i-1];
               end
               shadow_keys[pos] = key;
               shadow_names[pos] = name;
               shadow_ages[pos] = age;
               shadow_length++;
            end
         end
         alt_pkg::CMD_DELETE: begin
            if (shadow_length == 0) begin
               res.status = alt_pkg::ST_EMPTY;
            end else if (pos >= shadow_length) begin
               res.status = alt_pkg::ST_BAD_INDEX;
            end else begin
               for (i = pos; i + 1 < shadow_length; i++) begin
                  shadow_keys[i] = shadow_keys[i+1];
                  shadow_names[i] = shadow_names[i+1];
                  shadow_ages[i] = shadow_ages[i+1];
               end
               shadow_length--;
            end
         end
         alt_pkg::CMD_READ: begin
            if (shadow_length == 0) begin
               res.status = alt_pkg::ST_EMPTY;
            end else if (pos >= shadow_length) begin
               res.status = alt_pkg::ST_BAD_INDEX;
            end else begin
               res.key = shadow_keys[pos];
               res.name = shadow_names[pos];
               res.age = shadow_ages[pos];
            end
         end
         alt_pkg::CMD_FIND: begin
            if (shadow_length == 0) begin
               res.status = alt_pkg::ST_EMPTY;
            end else begin
               // The lowest matching index wins.
               res.status = alt_pkg::ST_NOT_FOUND;
               for (i = 0; i < shadow_length; i++) begin
                  if (!hit && shadow_keys[i] == key) begin
                     hit = 1'b1;
                     res.status = alt_pkg::ST_OK;
                     res.found_position = alt_pkg::POS_W'(i);
                     res.name = shadow_names[i];
                     res.age = shadow_ages[i];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      res.entry_count = alt_pkg::COUNT_W'(shadow_length);
      return res;
   endfunction

   task automatic report_mismatch(input string what, input list_result_type want,
                                  input list_result_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $time, what);
         $display("   expected status %0d pos %0d key %h name %h age %h count %0d",
                  want.status, want.found_position, want.key, want.name, want.age,
                  want.entry_count);
         $display("   actual   status %0d pos %0d key %h name %h age %h count %0d",
                  got.status, got.found_position, got.key, got.name, got.age,
                  got.entry_count);
      end
   endtask

   // Offer one command word and score it into the expected queue once taken.
   task automatic send_word(
      input logic [alt_pkg::CMD_W-1:0]  cmd,
      input logic [alt_pkg::POS_W-1:0]  pos,
      input logic [alt_pkg::KEY_W-1:0]  key,
      input logic [alt_pkg::NAME_W-1:0] name,
      input logic [alt_pkg::AGE_W-1:0]  age
   );
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_position <= pos;
      req_key_in <= key;
      req_name_in <= name;
      req_age_in <= age;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      pending_results.push_back(apply_list_command(cmd, pos, key, name, age));
   endtask

   // Stop sending and wait until every expected word has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Random command, mostly well formed against the current list contents.
   task automatic send_random_word();
      int                            pick;
      logic [alt_pkg::CMD_W-1:0]     cmd;
      logic [alt_pkg::POS_W-1:0]     pos;
      logic [alt_pkg::KEY_W-1:0]     key;
      logic [alt_pkg::NAME_W-1:0]    name;
      logic [alt_pkg::AGE_W-1:0]     age;
      pick = $urandom_range(99);
      if (pick < 2) begin
         cmd = alt_pkg::CMD_CLEAR;
      end else if (pick < 4) begin
         cmd = $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
      end else if (pick < 26) begin
         cmd = alt_pkg::CMD_APPEND;
      end else if (pick < 44) begin
         cmd = alt_pkg::CMD_INSERT;
      end else if (pick < 62) begin
         cmd = alt_pkg::CMD_DELETE;
      end else if (pick < 80) begin
         cmd = alt_pkg::CMD_READ;
      end else begin
         cmd = alt_pkg::CMD_FIND;
      end
      if (shadow_length > 0 && $urandom_range(9) < 8) begin
         pos = alt_pkg::POS_W'($urandom_range(shadow_length - 1));
      end else begin
         pos = alt_pkg::POS_W'($urandom_range(255));
      end
      // A small key pool makes duplicate keys and find hits common.
      if ($urandom_range(3) == 0) begin
         key = {$urandom, $urandom};
      end else begin
         key = {56'hC3A5_5A3C_0F96_69, 8'($urandom_range(5))};
      end
      if (cmd == alt_pkg::CMD_FIND && shadow_length > 0 && $urandom_range(3) != 0) begin
         key = shadow_keys[$urandom_range(shadow_length - 1)];
      end
      name = {$urandom, $urandom};
      age = alt_pkg::AGE_W'($urandom);
      send_word(cmd, pos, key, name, age);
   endtask

   // Commands on the empty list; read, delete, find and insert must be refused.
   task automatic test_empty_list();
      send_word(alt_pkg::CMD_CLEAR, 8'd0, '0, '0, '0);
      send_word(alt_pkg::CMD_READ, 8'd0, '0, '0, '0);
      send_word(alt_pkg::CMD_DELETE, 8'd0, '0, '0, '0);
      send_word(alt_pkg::CMD_FIND, 8'd0, '0, '0, '0);
      send_word(alt_pkg::CMD_INSERT, 8'd0, KEY_ONES, '1, '1);
      send_word(CMD_UNUSED_LO, 8'hFF, KEY_ONES, '1, '1);
      send_word(CMD_UNUSED_HI, 8'hFF, KEY_ONES, '1, '1);
   endtask

   // Edits at head, middle and tail, reads, and key searches.
   task automatic test_record_edits();
      send_word(alt_pkg::CMD_APPEND, 8'd0, KEY_ONES, '1, 16'hFFFF);
      send_word(alt_pkg::CMD_APPEND, 8'd0, '0, '0, 16'h0000);
      send_word(alt_pkg::CMD_APPEND, 8'd0, KEY_JOHN, NAME_ALICE, 16'd42);
      // Duplicate key in the middle: the search must return the lower index.
      send_word(alt_pkg::CMD_INSERT, 8'd1, KEY_ONES, 64'h1, 16'h0001);
      send_word(alt_pkg::CMD_INSERT, 8'd4, KEY_JOHN, NAME_ALICE, 16'd7);
      send_word(alt_pkg::CMD_READ, 8'hFF, '0, '0, '0);
      send_word(alt_pkg::CMD_READ, 8'd0, '0, '0, '0);
      send_word(alt_pkg::CMD_READ, 8'd3, '0, '0, '0);
      send_word(alt_pkg::CMD_FIND, 8'd0, KEY_ONES, '0, '0);
      send_word(alt_pkg::CMD_FIND, 8'd0, '0, '0, '0);
      send_word(alt_pkg::CMD_FIND, 8'd0, 64'h8000_0000_0000_0000, '0, '0);
      send_word(alt_pkg::CMD_DELETE, 8'd3, '0, '0, '0);
      send_word(alt_pkg::CMD_DELETE, 8'd0, '0, '0, '0);
      send_word(alt_pkg::CMD_DELETE, 8'd2, '0, '0, '0);
      send_word(alt_pkg::CMD_READ, 8'd1, '0, '0, '0);
      send_word(alt_pkg::CMD_FIND, 8'd0, KEY_JOHN, '0, '0);
   endtask

   // Fill past capacity while the receiver holds off, then pause until drained.
   task automatic test_full_list();
      int i;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_word(alt_pkg::CMD_CLEAR, 8'd0, '0, '0, '0);
      hold_request = 60;
      for (i = 0; i < LIST_DEPTH + 2; i++) begin
         send_word(alt_pkg::CMD_APPEND, 8'd0, {56'h5EED_0000_0000_00, 8'(i)},
                   {$urandom, $urandom}, alt_pkg::AGE_W'(i));
      end
      send_word(alt_pkg::CMD_INSERT, 8'd3, '0, '0, '0);
      send_word(alt_pkg::CMD_READ, 8'(LIST_DEPTH - 1), '0, '0, '0);
      send_word(alt_pkg::CMD_FIND, 8'd0, {56'h5EED_0000_0000_00, 8'd9}, '0, '0);
      send_word(alt_pkg::CMD_DELETE, 8'(LIST_DEPTH - 1), '0, '0, '0);
      wait_for_drain();
   endtask

   // One phase of random traffic at the given idle rates.
   task automatic test_random_traffic(input int count, input int sender_pct,
                                      input int receiver_pct);
      int i;
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
      for (i = 0; i < count; i++) begin
         send_random_word();
      end
      wait_for_drain();
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Score every accepted result word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed_result = {rsp_status, rsp_found_position, rsp_key_out, rsp_name_out,
                            rsp_age_out, rsp_entry_count};
         if (pending_results.size() == 0) begin
            report_mismatch("result word with nothing expected", '0, observed_result);
         end else begin
            oldest_result = pending_results.pop_front();
            if (observed_result !== oldest_result) begin
               report_mismatch("result word differs", oldest_result, observed_result);
            end
         end
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = alt_pkg::CMD_CLEAR;
      req_position = '0;
      req_key_in = '0;
      req_name_in = '0;
      req_age_in = '0;
      shadow_length = 0;
      mismatch_count = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_request = 0;
      quiet_cycles = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_record_edits();
      wait_for_drain();
      test_full_list();
      test_random_traffic(100, 0, 0);
      test_random_traffic(100, 73, 0);
      test_random_traffic(100, 0, 73);
      test_random_traffic(100, 14, 14);

      // Let any stray words show up before the verdict.
      repeat (LIST_DEPTH + 4) @(posedge clock);
      if (pending_results.size() != 0) begin
         report_mismatch("expected word never arrived", pending_results[0], '0);
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/alt_pkg.sv
hdl/alt_cell.sv
hdl/array_list_insert_delete_table.sv
hdl/alt_checker.sv
tb/sv/array_list_insert_delete_table_test.sv
